[rtl/gtoc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO timed output control - shared package
// Payload structs, state and status codes, timer constants and the state
// machine type used across the block.
// ----------------------------------------------------------------------------
package gtoc_pkg;

  localparam int unsigned NumPinsDef = 64;

  // Timer limits and the reciprocal used to divide by one thousand
  localparam logic [21:0] MaxTimerSecs = 22'd2147483;
  localparam logic [31:0] MsPerSec     = 32'd1000;
  localparam logic [31:0] RoundUpMs    = 32'd999;
  localparam logic [31:0] RemClamp     = 32'h8000_0000;
  localparam logic [31:0] DivMagic     = 32'h1062_4DD3;
  localparam int unsigned DivShift     = 38;

  // Action codes
  localparam logic [1:0] ActTick = 2'd0;
  localparam logic [1:0] ActGet  = 2'd1;
  localparam logic [1:0] ActSet  = 2'd2;

  // Pin state codes
  localparam logic [1:0] PinLow  = 2'd0;
  localparam logic [1:0] PinHigh = 2'd1;
  localparam logic [1:0] PinRel  = 2'd2;
  localparam logic [1:0] PinRel3 = 2'd3;

  // Status codes
  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatUnavail   = 2'd1;
  localparam logic [1:0] StatRelTimer  = 2'd2;
  localparam logic [1:0] StatSecsRange = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [7:0]  pin;
    logic [1:0]  start_state;
    logic        has_timer;
    logic [31:0] seconds;
    logic [1:0]  end_state;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  pin_state;
    logic        timer_running;
    logic [21:0] seconds_left;
    logic [1:0]  pending_state;
    logic [63:0] drive_enable;
    logic [63:0] drive_level;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_CMD,
    S_REM,
    S_CALC,
    S_DONE
  } state_e;

  // Fold the spare code three onto release
  function automatic logic [1:0] norm_state(input logic [1:0] s);
    norm_state = (s == PinRel3) ? PinRel : s;
  endfunction

endpackage
`default_nettype wire

[rtl/gtoc_secs_left.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO timed output control - remaining seconds
// Two-stage pipeline: clamp and round the remaining milliseconds, then divide
// by one thousand through a reciprocal multiply and saturate.
// ----------------------------------------------------------------------------
module gtoc_secs_left (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] deadline_i,
  input  logic [31:0] now_i,
  output logic        valid_o,
  output logic [21:0] secs_o
);
  import gtoc_pkg::*;

  logic [31:0]         rem;
  logic [31:0]         x_d, x_q;
  logic [63:0]         prod_q;
  logic                v1_q, v2_q;
  logic [63-DivShift:0] quot;

  // Clamp a backwards-running clock, then bias for round-up
  always_comb begin
    rem = deadline_i - now_i;
    if (rem > RemClamp) begin
      rem = RemClamp;
    end
    x_d = rem + RoundUpMs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    prod_q <= 64'(x_q) * 64'(DivMagic);
  end

  assign quot    = prod_q[63:DivShift];
  assign secs_o  = (quot > (64-DivShift)'(MaxTimerSecs)) ? MaxTimerSecs : quot[21:0];
  assign valid_o = v2_q;

endmodule
`default_nettype wire

[rtl/gpio_timed_output_control_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO timed output control - top level
// Per-pin output controller with one-shot timers held in a deadline memory.
// ----------------------------------------------------------------------------
// An item is taken on a rising edge with start high and busy low. Every item
// first sweeps all NUM_PINS deadlines out of the deadline memory, one pin a
// cycle, expiring timers that are due at the item's millisecond time; then a
// get or set is applied. A get on a pin with a running timer also passes
// through the divide-by-thousand pipeline before its result is formed. Each
// result appears on res_o for exactly one cycle with res_valid_o high and
// cannot be stalled: the receiver must take it then. busy falls in the same
// cycle, so the next start may land while the result is shown. The
// available-pins register is written over the cfg channel, which is always
// ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module gpio_timed_output_control_top #(
  parameter int unsigned NUM_PINS = gtoc_pkg::NumPinsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  gtoc_pkg::req_t req_i,
  output logic          res_valid_o,
  output gtoc_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [63:0]   cfg_data_i
);
  import gtoc_pkg::*;

  localparam int unsigned IdxW  = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned Depth = 1 << IdxW;

  state_e state_q, state_d;

  // Item and sweep control
  req_t            item_q, item_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;

  // Per-pin flags
  logic [NUM_PINS-1:0] en_q, en_d;
  logic [NUM_PINS-1:0] lvl_q, lvl_d;
  logic [NUM_PINS-1:0] arm_q, arm_d;
  logic [NUM_PINS-1:0] fhi_q, fhi_d;
  logic [NUM_PINS-1:0] frel_q, frel_d;
  logic [63:0]         avail_q;

  // Result scratch
  logic [1:0]  status_q, status_d;
  logic [1:0]  pstate_q, pstate_d;
  logic        running_q, running_d;
  logic [21:0] left_q, left_d;
  logic [1:0]  pend_q, pend_d;
  res_t        res_q, res_d;
  logic        res_valid_q;

  // Deadline memory
  logic [31:0]     mem [Depth];
  logic [IdxW-1:0] rd_addr;
  logic [31:0]     rd_data_q;
  logic            mem_we;
  logic [31:0]     mul_q;

  // Helpers
  logic [IdxW-1:0] pidx;
  logic            pin_ok;
  logic [1:0]      init_s, fin_s, cur_s, pend_s;
  logic [31:0]     diff;
  logic            expire;
  logic            secs_bad;
  logic            calc_start, calc_valid;
  logic [21:0]     calc_secs;

  assign pidx     = item_q.pin[IdxW-1:0];
  assign pin_ok   = ({1'b0, item_q.pin} < 9'(NUM_PINS)) && avail_q[item_q.pin[5:0]];
  assign init_s   = norm_state(item_q.start_state);
  assign fin_s    = norm_state(item_q.end_state);
  assign cur_s    = !en_q[pidx] ? PinRel : (lvl_q[pidx] ? PinHigh : PinLow);
  assign pend_s   = frel_q[pidx] ? PinRel : (fhi_q[pidx] ? PinHigh : PinLow);
  assign secs_bad = (item_q.seconds == 32'd0) || (item_q.seconds > 32'(MaxTimerSecs));

  // A timer is due when now minus deadline is non-negative as a signed value
  assign diff   = item_q.now_ms - rd_data_q;
  assign expire = rd_vld_q && arm_q[rd_idx_q] && !diff[31];

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    cnt_d      = cnt_q;
    en_d       = en_q;
    lvl_d      = lvl_q;
    arm_d      = arm_q;
    fhi_d      = fhi_q;
    frel_d     = frel_q;
    status_d   = status_q;
    pstate_d   = pstate_q;
    running_d  = running_q;
    left_d     = left_q;
    pend_d     = pend_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    rd_addr    = pidx;
    calc_start = 1'b0;

    // Expire the pin read in the previous sweep cycle
    if (expire) begin
      arm_d[rd_idx_q]  = 1'b0;
      fhi_d[rd_idx_q]  = 1'b0;
      frel_d[rd_idx_q] = 1'b0;
      en_d[rd_idx_q]   = !frel_q[rd_idx_q];
      lvl_d[rd_idx_q]  = !frel_q[rd_idx_q] && fhi_q[rd_idx_q];
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d  = req_i;
          cnt_d   = '0;
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        rd_addr = cnt_q[IdxW-1:0];
        if (cnt_q == CntW'(NUM_PINS)) begin
          state_d = S_CMD;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      S_CMD: begin
        status_d  = StatOk;
        pstate_d  = PinLow;
        running_d = 1'b0;
        left_d    = '0;
        pend_d    = PinLow;
        state_d   = S_DONE;
        if (item_q.action == ActGet || item_q.action == ActSet) begin
          if (!pin_ok) begin
            status_d = StatUnavail;
          end else if (item_q.action == ActGet) begin
            pstate_d = cur_s;
            if (arm_q[pidx]) begin
              running_d = 1'b1;
              pend_d    = pend_s;
              state_d   = S_REM;
            end
          end else if (!item_q.has_timer) begin
            arm_d[pidx]  = 1'b0;
            fhi_d[pidx]  = 1'b0;
            frel_d[pidx] = 1'b0;
            en_d[pidx]   = (init_s != PinRel);
            lvl_d[pidx]  = (init_s == PinHigh);
            pstate_d     = init_s;
          end else if (init_s == PinRel) begin
            status_d = StatRelTimer;
            pstate_d = cur_s;
          end else if (secs_bad) begin
            status_d = StatSecsRange;
            pstate_d = cur_s;
          end else begin
            mem_we       = 1'b1;
            arm_d[pidx]  = 1'b1;
            fhi_d[pidx]  = (fin_s == PinHigh);
            frel_d[pidx] = (fin_s == PinRel);
            en_d[pidx]   = 1'b1;
            lvl_d[pidx]  = (init_s == PinHigh);
            pstate_d     = init_s;
          end
        end
      end
      S_REM: begin
        calc_start = 1'b1;
        state_d    = S_CALC;
      end
      S_CALC: begin
        if (calc_valid) begin
          left_d  = calc_secs;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_d.status        = status_q;
        res_d.pin_state     = pstate_q;
        res_d.timer_running = running_q;
        res_d.seconds_left  = left_q;
        res_d.pending_state = pend_q;
        res_d.drive_enable  = 64'(en_q);
        res_d.drive_level   = 64'(lvl_q);
        state_d             = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      en_q        <= '0;
      lvl_q       <= '0;
      arm_q       <= '0;
      fhi_q       <= '0;
      frel_q      <= '0;
      avail_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= (state_q == S_SWEEP) && (cnt_q < CntW'(NUM_PINS));
      en_q        <= en_d;
      lvl_q       <= lvl_d;
      arm_q       <= arm_d;
      fhi_q       <= fhi_d;
      frel_q      <= frel_d;
      res_valid_q <= (state_q == S_DONE);
      if (cfg_valid_i) begin
        avail_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    rd_idx_q  <= cnt_q[IdxW-1:0];
    status_q  <= status_d;
    pstate_q  <= pstate_d;
    running_q <= running_d;
    left_q    <= left_d;
    pend_q    <= pend_d;
    res_q     <= res_d;
    mul_q     <= item_q.seconds * MsPerSec;
  end

  // Deadline memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[pidx] <= item_q.now_ms + mul_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  gtoc_secs_left u_secs_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (calc_start),
    .deadline_i (rd_data_q),
    .now_i      (item_q.now_ms),
    .valid_o    (calc_valid),
    .secs_o     (calc_secs)
  );

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

endmodule
`default_nettype wire
